// ===== hdl/tms_pkg.sv =====
// Shared types, constants and helper functions of the triangle midpoint subdivider.
package tms_pkg;

	localparam int ATTR_WIDTH      = 16;
	localparam int NUM_ATTR        = 11;
	localparam int FRAC_BITS       = 12;
	localparam int TRI_QUEUE_DEPTH = 2;
	localparam int SQ_WIDTH        = 2 * ATTR_WIDTH;
	localparam int DIV_WIDTH       = ATTR_WIDTH + FRAC_BITS + 2;

	localparam int A_POS_X = 0;
	localparam int A_NRM_X = 3;
	localparam int A_TAN_X = 6;
	localparam int A_TEX_U = 9;

	typedef logic signed [ATTR_WIDTH-1:0] attr_t;
	typedef attr_t [NUM_ATTR-1:0] attr_vec_t;

	typedef struct packed {
		attr_t pos_x;
		attr_t pos_y;
		attr_t pos_z;
		attr_t nrm_x;
		attr_t nrm_y;
		attr_t nrm_z;
		attr_t tan_x;
		attr_t tan_y;
		attr_t tan_z;
		attr_t tex_u;
		attr_t tex_v;
	} vertex_t;

	typedef struct packed {
		attr_t out_pos_x;
		attr_t out_pos_y;
		attr_t out_pos_z;
		attr_t out_nrm_x;
		attr_t out_nrm_y;
		attr_t out_nrm_z;
		attr_t out_tan_x;
		attr_t out_tan_y;
		attr_t out_tan_z;
		attr_t out_tex_u;
		attr_t out_tex_v;
		logic  run_last;
	} result_t;

	typedef struct packed {
		attr_vec_t v0;
		attr_vec_t v1;
		attr_vec_t v2;
	} tri_t;

	function automatic attr_vec_t vertex_to_vec(vertex_t v);
		attr_vec_t a;
		a[0]  = v.pos_x;
		a[1]  = v.pos_y;
		a[2]  = v.pos_z;
		a[3]  = v.nrm_x;
		a[4]  = v.nrm_y;
		a[5]  = v.nrm_z;
		a[6]  = v.tan_x;
		a[7]  = v.tan_y;
		a[8]  = v.tan_z;
		a[9]  = v.tex_u;
		a[10] = v.tex_v;
		return a;
	endfunction

	function automatic result_t vec_to_result(attr_vec_t a, logic last);
		result_t r;
		r.out_pos_x = a[0];
		r.out_pos_y = a[1];
		r.out_pos_z = a[2];
		r.out_nrm_x = a[3];
		r.out_nrm_y = a[4];
		r.out_nrm_z = a[5];
		r.out_tan_x = a[6];
		r.out_tan_y = a[7];
		r.out_tan_z = a[8];
		r.out_tex_u = a[9];
		r.out_tex_v = a[10];
		r.run_last  = last;
		return r;
	endfunction

	// Floor of the halved sum is the upper bits of the full-width sum.
	function automatic attr_t half_sum(attr_t a, attr_t b);
		logic signed [ATTR_WIDTH:0] s;
		s = {a[ATTR_WIDTH-1], a} + {b[ATTR_WIDTH-1], b};
		return s[ATTR_WIDTH:1];
	endfunction

endpackage

// ===== hdl/triangle_midpoint_subdivider_core.sv =====
// Top level of the triangle midpoint subdivider.
//
// Vertices enter one word at a time on the vertex port: a word is taken at a
// clock edge where push is high and full is low. Every third vertex closes a
// triangle, and six result words follow on the result port in the order
// v0, v1, v2, m01, m12, m02; run_last is set on the sixth. A result word is
// shown while empty is low and is taken at an edge where pop is high.
// The front end only holds the first two vertices and hands each complete
// triangle to a queue of TRI_QUEUE_DEPTH triangles, so vertices keep flowing
// while the back end works. The back end picks up a triangle and emits the
// three corners, then for each midpoint forms the halved sums and, for the
// normal and for the tangent, squares and sums the three components, takes the
// square root and runs up to three divisions, each a setup and then the quotient
// bits, on the shared bit-serial root and divider, and then emits the midpoint.
// After the third vertex the triangle is written into the queue, the back end
// picks it up, and the first corner is then registered in the output word.
// Reset clears the vertex position and empties both the queue and the output
// register. When the receiver stalls, the output word holds, the back end
// waits, the queue fills and finally full rises on a triangle's third vertex.
module triangle_midpoint_subdivider_core #(
	parameter int TRI_QUEUE_DEPTH = tms_pkg::TRI_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tms_pkg::vertex_t vertex,
	input  logic             push,
	output logic             full,
	output tms_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);
	import tms_pkg::*;

	logic q_full;
	logic q_push;
	tri_t q_in;
	logic q_pop;
	tri_t q_out;
	logic q_empty;

	tms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vertex (vertex),
		.push   (push),
		.full   (full),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	tms_tri_queue #(
		.DEPTH (TRI_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.data_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.data_out (q_out),
		.empty    (q_empty)
	);

	tms_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tri_in  (q_out),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

// ===== hdl/tms_front.sv =====
// Front end: takes vertices, holds the first two of a triangle, queues whole triangles.
module tms_front (
	input  logic           clk,
	input  logic           arst_n,
	input  tms_pkg::vertex_t vertex,
	input  logic           push,
	output logic           full,
	input  logic           q_full,
	output logic           q_push,
	output tms_pkg::tri_t  q_data
);
	import tms_pkg::*;

	localparam logic [1:0] SLOT_V0 = 2'd0;
	localparam logic [1:0] SLOT_V1 = 2'd1;
	localparam logic [1:0] SLOT_V2 = 2'd2;

	logic [1:0] slot_q;
	attr_vec_t  v0_q;
	attr_vec_t  v1_q;
	attr_vec_t  cur;
	logic       accept;

	assign cur    = vertex_to_vec(vertex);
	assign full   = (slot_q == SLOT_V2) && q_full;
	assign accept = push && !full;
	assign q_push = accept && (slot_q == SLOT_V2);
	assign q_data = '{v0: v0_q, v1: v1_q, v2: cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_V0;
		end else if (accept) begin
			unique case (slot_q)
				SLOT_V0: slot_q <= SLOT_V1;
				SLOT_V1: slot_q <= SLOT_V2;
				default: slot_q <= SLOT_V0;
			endcase
		end
	end

	// The unused slot code behaves like the first slot.
	always_ff @(posedge clk) begin
		if (accept && slot_q == SLOT_V1) begin
			v1_q <= cur;
		end else if (accept && slot_q != SLOT_V2) begin
			v0_q <= cur;
		end
	end

endmodule

// ===== hdl/tms_tri_queue.sv =====
// Short queue of whole triangles between the front and the back end.
module tms_tri_queue #(
	parameter int DEPTH = tms_pkg::TRI_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tms_pkg::tri_t data_in,
	output logic          full,
	input  logic          pop,
	output tms_pkg::tri_t data_out,
	output logic          empty
);
	import tms_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tri_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= data_in;
	end

endmodule

// ===== hdl/tms_back.sv =====
// Back end: emits corners, forms midpoints and renormalizes them with a shared root and divider.
module tms_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tms_pkg::tri_t   tri_in,
	input  logic            q_empty,
	output logic            q_pop,
	output tms_pkg::result_t result,
	output logic            empty,
	input  logic            pop
);
	import tms_pkg::*;

	localparam int W     = ATTR_WIDTH;
	localparam int CNT_W = $clog2(DIV_WIDTH + 1);

	localparam logic [2:0] IDX_V0  = 3'd0;
	localparam logic [2:0] IDX_V1  = 3'd1;
	localparam logic [2:0] IDX_V2  = 3'd2;
	localparam logic [2:0] IDX_M01 = 3'd3;
	localparam logic [2:0] IDX_M12 = 3'd4;
	localparam logic [2:0] IDX_M02 = 3'd5;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CORNER = 8'b0000_0010,
		S_HALF   = 8'b0000_0100,
		S_SQ     = 8'b0000_1000,
		S_SQRT   = 8'b0001_0000,
		S_DIVSET = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_MID    = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [2:0]           idx_q;
	logic                 vec_q;
	logic [1:0]           comp_q;
	logic [CNT_W-1:0]     cnt_q;
	attr_vec_t            hs_q;
	logic [SQ_WIDTH-1:0]  acc_q;
	logic [SQ_WIDTH-1:0]  sq_n_q;
	logic [W+1:0]         sq_rem_q;
	logic [W-1:0]         root_q;
	logic [DIV_WIDTH-1:0] dvd_q;
	logic [W:0]           drem_q;
	logic [DIV_WIDTH-1:0] quo_q;
	attr_t                unit_q [6];
	result_t              out_q;
	logic                 out_valid_q;

	attr_vec_t            va;
	attr_vec_t            vb;
	attr_vec_t            hsum_c;
	attr_vec_t            corner_c;
	attr_vec_t            mid_c;
	attr_t                comp_val;
	logic [W-1:0]         mag_c;
	logic [SQ_WIDTH-1:0]  sq_c;
	logic [W+1:0]         sq_trial_rem;
	logic [W+1:0]         sq_trial;
	logic                 sq_ge;
	logic [W:0]           dvs;
	logic [W+1:0]         dtr;
	logic                 d_ge;
	logic [DIV_WIDTH-1:0] quo_next;
	logic [2:0]           unit_idx;
	logic                 slot_free;
	logic                 out_load;

	assign slot_free = !out_valid_q || pop;
	assign out_load  = slot_free && (state_q == S_CORNER || state_q == S_MID);
	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign q_pop     = (state_q == S_MID) && slot_free && (idx_q == IDX_M02);

	assign va = (idx_q == IDX_M12) ? tri_in.v1 : tri_in.v0;
	assign vb = (idx_q == IDX_M01) ? tri_in.v1 : tri_in.v2;

	always_comb begin
		for (int k = 0; k < NUM_ATTR; k++) begin
			hsum_c[k] = half_sum(va[k], vb[k]);
		end
	end

	always_comb begin
		case (idx_q)
			IDX_V0:  corner_c = tri_in.v0;
			IDX_V1:  corner_c = tri_in.v1;
			default: corner_c = tri_in.v2;
		endcase
	end

	always_comb begin
		mid_c = hs_q;
		for (int k = 0; k < 3; k++) begin
			mid_c[A_NRM_X + k] = unit_q[k];
			mid_c[A_TAN_X + k] = unit_q[3 + k];
		end
	end

	// Component under work: normal while vec_q is low, tangent otherwise.
	always_comb begin
		case ({vec_q, comp_q})
			3'b000:  comp_val = hs_q[A_NRM_X];
			3'b001:  comp_val = hs_q[A_NRM_X + 1];
			3'b010:  comp_val = hs_q[A_NRM_X + 2];
			3'b100:  comp_val = hs_q[A_TAN_X];
			3'b101:  comp_val = hs_q[A_TAN_X + 1];
			default: comp_val = hs_q[A_TAN_X + 2];
		endcase
	end

	assign mag_c    = comp_val[W-1] ? (~comp_val + 1'b1) : comp_val;
	assign sq_c     = mag_c * mag_c;
	assign unit_idx = vec_q ? (3'd3 + {1'b0, comp_q}) : {1'b0, comp_q};

	// Square root, two radicand bits per cycle.
	assign sq_trial_rem = {sq_rem_q[W-1:0], sq_n_q[SQ_WIDTH-1 -: 2]};
	assign sq_trial     = {root_q, 2'b01};
	assign sq_ge        = (sq_trial_rem >= sq_trial);

	// Restoring divider by twice the root, one quotient bit per cycle.
	assign dvs      = {root_q, 1'b0};
	assign dtr      = {drem_q, dvd_q[DIV_WIDTH-1]};
	assign d_ge     = (dtr >= {1'b0, dvs});
	assign quo_next = {quo_q[DIV_WIDTH-2:0], d_ge};

	function automatic attr_t sat_quot(logic [DIV_WIDTH-1:0] q, logic neg);
		logic [W-1:0] lo;
		lo = q[W-1:0];
		if (!neg) begin
			if (q > DIV_WIDTH'((1 << (W - 1)) - 1)) return {1'b0, {(W-1){1'b1}}};
			return lo;
		end
		if (q > DIV_WIDTH'(1 << (W - 1))) return {1'b1, {(W-1){1'b0}}};
		return ~lo + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= IDX_V0;
			vec_q       <= 1'b0;
			comp_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						idx_q   <= IDX_V0;
						state_q <= S_CORNER;
					end
				end
				S_CORNER: begin
					if (slot_free) begin
						out_q <= vec_to_result(corner_c, 1'b0);
						idx_q <= idx_q + 1'b1;
						if (idx_q == IDX_V2) state_q <= S_HALF;
					end
				end
				S_HALF: begin
					hs_q    <= hsum_c;
					acc_q   <= '0;
					vec_q   <= 1'b0;
					comp_q  <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					acc_q <= acc_q + sq_c;
					if (comp_q == 2'd2) begin
						sq_n_q   <= acc_q + sq_c;
						sq_rem_q <= '0;
						root_q   <= '0;
						cnt_q    <= '0;
						comp_q   <= '0;
						state_q  <= S_SQRT;
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
				S_SQRT: begin
					sq_n_q   <= {sq_n_q[SQ_WIDTH-3:0], 2'b00};
					sq_rem_q <= sq_ge ? (sq_trial_rem - sq_trial) : sq_trial_rem;
					root_q   <= {root_q[W-2:0], sq_ge};
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(W - 1)) state_q <= S_DIVSET;
				end
				S_DIVSET: begin
					if (root_q == '0) begin
						// A zero-length vector renormalizes to zero.
						unit_q[unit_idx] <= '0;
						if (comp_q != 2'd2) begin
							comp_q <= comp_q + 1'b1;
						end else if (!vec_q) begin
							vec_q   <= 1'b1;
							comp_q  <= '0;
							acc_q   <= '0;
							state_q <= S_SQ;
						end else begin
							state_q <= S_MID;
						end
					end else begin
						dvd_q   <= (DIV_WIDTH'(mag_c) << (FRAC_BITS + 1)) + DIV_WIDTH'(root_q);
						drem_q  <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q  <= {dvd_q[DIV_WIDTH-2:0], 1'b0};
					drem_q <= d_ge ? (W+1)'(dtr - {1'b0, dvs}) : dtr[W:0];
					quo_q  <= quo_next;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_WIDTH - 1)) begin
						unit_q[unit_idx] <= sat_quot(quo_next, comp_val[W-1]);
						if (comp_q != 2'd2) begin
							comp_q  <= comp_q + 1'b1;
							state_q <= S_DIVSET;
						end else if (!vec_q) begin
							vec_q   <= 1'b1;
							comp_q  <= '0;
							acc_q   <= '0;
							state_q <= S_SQ;
						end else begin
							state_q <= S_MID;
						end
					end
				end
				S_MID: begin
					if (slot_free) begin
						out_q   <= vec_to_result(mid_c, idx_q == IDX_M02);
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == IDX_M02) ? S_IDLE : S_HALF;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/tms_checker.sv =====
// Port checker for the triangle midpoint subdivider and its bind statement.
module tms_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input tms_pkg::result_t result,
	input logic             empty,
	input logic             pop
);
	import tms_pkg::*;

	// In reset no result word may be offered.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result offered during reset");

	// In reset the block sits at a triangle's first vertex and cannot be full.
	a_reset_not_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("full raised during reset");

	// A stalled result word stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result word changed while stalled");

endmodule

bind triangle_midpoint_subdivider_core tms_checker u_tms_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.result (result),
	.empty  (empty),
	.pop    (pop)
);

// ===== tb/sv/tms_scoreboard.sv =====
// Checker for the triangle midpoint subdivider: predicts emitted vertices and compares them.
module tms_scoreboard
	import tms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  vertex_t vertex,
	input  logic    push,
	input  logic    full,
	input  result_t result,
	input  logic    empty,
	input  logic    pop,
	output int      fail_count,
	output int      pending_words
);

	typedef logic signed [ATTR_WIDTH-1:0] comp_arr_t [NUM_ATTR];

	result_t   expected_words[$];
	comp_arr_t held_v0, held_v1;
	logic [1:0] slot;
	string     field_name[NUM_ATTR] = '{"out_pos_x", "out_pos_y", "out_pos_z",
		"out_nrm_x", "out_nrm_y", "out_nrm_z", "out_tan_x", "out_tan_y", "out_tan_z",
		"out_tex_u", "out_tex_v"};

	assign pending_words = expected_words.size();

	function automatic comp_arr_t split_vertex(vertex_t v);
		comp_arr_t a;
		for (int k = 0; k < NUM_ATTR; k++)
			a[k] = v[NUM_ATTR*ATTR_WIDTH-1-ATTR_WIDTH*k -: ATTR_WIDTH];
		return a;
	endfunction

	function automatic result_t join_word(comp_arr_t a, logic last);
		result_t r;
		for (int k = 0; k < NUM_ATTR; k++)
			r[NUM_ATTR*ATTR_WIDTH-ATTR_WIDTH*k -: ATTR_WIDTH] = a[k];
		r[0] = last;
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [ATTR_WIDTH-1:0] clamp(longint v);
		longint hi;
		hi = (longint'(1) <<< (ATTR_WIDTH-1)) - 1;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return v[ATTR_WIDTH-1:0];
	endfunction

	// Rescales three components in place to unit length in Q3.12.
	function automatic void unit_length(ref comp_arr_t a, input int base);
		longint unsigned len2, s, q, num, m;
		len2 = 0;
		for (int k = 0; k < 3; k++) begin
			m = (a[base+k] < 0) ? -longint'(a[base+k]) : longint'(a[base+k]);
			len2 += m * m;
		end
		s = int_sqrt(len2);
		for (int k = 0; k < 3; k++) begin
			if (s == 0) begin
				a[base+k] = '0;
			end else begin
				m = (a[base+k] < 0) ? -longint'(a[base+k]) : longint'(a[base+k]);
				num = m << FRAC_BITS;
				q = (2 * num + s) / (2 * s);
				a[base+k] = clamp((a[base+k] < 0) ? -longint'(q) : longint'(q));
			end
		end
	endfunction

	function automatic result_t midpoint_word(comp_arr_t a, comp_arr_t b, logic last);
		comp_arr_t h;
		for (int k = 0; k < NUM_ATTR; k++)
			h[k] = (longint'(a[k]) + longint'(b[k])) >>> 1;
		unit_length(h, A_NRM_X);
		unit_length(h, A_TAN_X);
		return join_word(h, last);
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		fail_count++;
	endtask

	// Appends one expected word at the tail of the queue.
	task automatic queue_word(result_t w);
		expected_words = {expected_words, w};
	endtask

	always @(posedge clk or negedge arst_n) begin
		comp_arr_t cur;
		result_t   exp_w;
		if (!arst_n) begin
			slot = 0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					exp_w = expected_words.pop_front();
					for (int k = 0; k < NUM_ATTR; k++)
						if (result[NUM_ATTR*ATTR_WIDTH-ATTR_WIDTH*k -: ATTR_WIDTH] !==
								exp_w[NUM_ATTR*ATTR_WIDTH-ATTR_WIDTH*k -: ATTR_WIDTH])
							report_mismatch($sformatf("%s got %h expected %h", field_name[k],
								result[NUM_ATTR*ATTR_WIDTH-ATTR_WIDTH*k -: ATTR_WIDTH],
								exp_w[NUM_ATTR*ATTR_WIDTH-ATTR_WIDTH*k -: ATTR_WIDTH]));
					if (result.run_last !== exp_w.run_last)
						report_mismatch($sformatf("run_last got %b expected %b",
							result.run_last, exp_w.run_last));
				end
			end
			if (push && !full) begin
				cur = split_vertex(vertex);
				if (slot == 1) begin
					held_v1 = cur;
					slot = 2;
				end else if (slot == 2) begin
					queue_word(join_word(held_v0, 1'b0));
					queue_word(join_word(held_v1, 1'b0));
					queue_word(join_word(cur, 1'b0));
					queue_word(midpoint_word(held_v0, held_v1, 1'b0));
					queue_word(midpoint_word(held_v1, cur, 1'b0));
					queue_word(midpoint_word(held_v0, cur, 1'b1));
					slot = 0;
				end else begin
					held_v0 = cur;
					slot = 1;
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the triangle midpoint subdivider: stimulus, handshake pacing and verdict.
module tb;
	import tms_pkg::*;

	logic    clk;
	logic    arst_n;
	vertex_t vertex;
	logic    push;
	logic    full;
	result_t result;
	logic    empty;
	logic    pop;
	int      fail_count;
	int      pending_words;

	// The sender runs without gaps while this is set, and so does the receiver.
	bit      steady_phase;
	int      words_popped;
	int      idle_cycles;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int RANDOM_ITEMS   = 400;

	triangle_midpoint_subdivider_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.vertex(vertex),
		.push  (push),
		.full  (full),
		.result(result),
		.empty (empty),
		.pop   (pop)
	);

	tms_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex       (vertex),
		.push         (push),
		.full         (full),
		.result       (result),
		.empty        (empty),
		.pop          (pop),
		.fail_count   (fail_count),
		.pending_words(pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Builds a vertex from eleven attribute values, position first.
	function automatic vertex_t make_vertex(attr_t a [NUM_ATTR]);
		vertex_t v;
		for (int k = 0; k < NUM_ATTR; k++)
			v[NUM_ATTR*ATTR_WIDTH-1-ATTR_WIDTH*k -: ATTR_WIDTH] = a[k];
		return v;
	endfunction

	function automatic vertex_t fill_vertex(attr_t val);
		attr_t a [NUM_ATTR];
		foreach (a[k])
			a[k] = val;
		return make_vertex(a);
	endfunction

	// Random vertex. Normals and tangents are mostly near unit length, with
	// some tiny or full-range vectors so that rounding and zero length show up.
	function automatic vertex_t random_vertex();
		attr_t a [NUM_ATTR];
		int    style;
		foreach (a[k])
			a[k] = attr_t'($urandom());
		style = $urandom_range(0, 9);
		for (int k = A_NRM_X; k < A_TEX_U; k++) begin
			if (style < 6)
				a[k] = attr_t'($urandom_range(0, 8192) - 4096);
			else if (style < 8)
				a[k] = attr_t'($urandom_range(0, 6) - 3);
		end
		return make_vertex(a);
	endfunction

	// Offers one word and waits until the block takes it.
	task automatic send_vertex(vertex_t v);
		while (!steady_phase && $urandom_range(0, 99) < 22) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		vertex <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Receiver: random stalls, a quiet stretch, and one long hold-off that lets
	// the triangle queue fill while the sender keeps pushing.
	initial begin
		int hold;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (empty == 1'b0 && pop == 1'b1)
				words_popped++;
			if (words_popped == 30) begin
				words_popped++;
				pop <= 1'b0;
				for (hold = 0; hold < 3000; hold++)
					@(posedge clk);
			end else begin
				pop <= steady_phase || ($urandom_range(0, 99) >= 22);
			end
		end
	end

	// Cycles with no accepted word on either side end the run.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		attr_t a [NUM_ATTR];
		vertex_t v;
		words_popped = 0;
		steady_phase = 1'b0;
		arst_n = 1'b0;
		push   = 1'b0;
		vertex = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes: triangles of all-max, all-min and all-zero vertices, then mixed signs
		// that make the midpoint normal cancel to a zero-length vector.
		send_vertex(fill_vertex(16'sh7fff));
		send_vertex(fill_vertex(16'sh8000));
		send_vertex(fill_vertex(16'sh0000));
		send_vertex(fill_vertex(16'sh8000));
		send_vertex(fill_vertex(16'sh8000));
		send_vertex(fill_vertex(16'sh7fff));
		foreach (a[k])
			a[k] = 16'sh1000;
		send_vertex(make_vertex(a));
		foreach (a[k])
			a[k] = -16'sh1000;
		send_vertex(make_vertex(a));
		a[A_NRM_X] = 16'sh7fff;
		a[A_TAN_X+2] = 16'sh0001;
		send_vertex(make_vertex(a));
		// Tiny vectors, where the root is a few units and rounding dominates.
		foreach (a[k])
			a[k] = 16'sh0001;
		send_vertex(make_vertex(a));
		a[A_NRM_X+1] = -16'sh0002;
		a[A_TAN_X] = 16'sh0000;
		send_vertex(make_vertex(a));
		send_vertex(fill_vertex(16'sh0000));

		// Let everything drain once before the random part.
		push <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady_phase = (n >= 150 && n < 210);
			if (n == 300) begin
				// Sender pause until the block has delivered every word.
				push <= 1'b0;
				@(posedge clk);
				while (pending_words != 0)
					@(posedge clk);
			end
			v = random_vertex();
			send_vertex(v);
		end
		push <= 1'b0;
		steady_phase = 1'b0;
		@(posedge clk);

		while (pending_words != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tms_pkg.sv
hdl/tms_front.sv
hdl/tms_tri_queue.sv
hdl/tms_back.sv
hdl/triangle_midpoint_subdivider_core.sv
hdl/tms_checker.sv
tb/sv/tms_scoreboard.sv
tb/sv/tb.sv
